// ----- rtl/dtog_pkg.sv -----
// shared constants, codes and helpers of the depth-to-occupancy-grid block
`timescale 1ns / 1ps
package dtog_pkg;

  // default sizes
  localparam int GRID_DIM_DEF = 512;
  localparam int IMG_COLS_DEF = 1024;
  localparam int IMG_ROWS_DEF = 512;

  // width of the read position of a cell
  localparam int CELL_W = 18;

  // operation codes
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_PROJECT  = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_LOAD_COL = 3'd3;
  localparam logic [2:0] OP_LOAD_ROW = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MAX_DEPTH   = 3'd0;
  localparam logic [2:0] REG_CELLS_PER_M = 3'd1;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FIRST_ROW   = 3'd4;
  localparam logic [2:0] REG_RED_A       = 3'd5;
  localparam logic [2:0] REG_RED_B       = 3'd6;

  // register reset values
  localparam logic [15:0] MAX_DEPTH_RST   = 16'd30720;
  localparam logic [15:0] CELLS_PER_M_RST = 16'd5120;
  localparam logic [9:0]  GRID_WIDTH_RST  = 10'd400;
  localparam logic [9:0]  GRID_HEIGHT_RST = 10'd400;
  localparam logic [8:0]  FIRST_ROW_RST   = 9'd144;
  localparam logic [7:0]  RED_A_RST       = 8'd64;
  localparam logic [7:0]  RED_B_RST       = 8'd192;

  // value of an occupied cell
  localparam logic [6:0] OCC_VALUE = 7'd100;

  // magnitude of a q1.15 value
  function automatic logic [15:0] mag16(logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

endpackage

// ----- rtl/dtog_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dtog_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, quot[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        quot <= num;
        rem  <= '0;
      end else if (busy) begin
        quot <= {quot[NUM_W-2:0], ge};
        rem  <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/depth_to_occupancy_grid.sv -----
// depth-to-occupancy-grid projection block, top level
// one item at a time; table loads and dropped pixels are done at accept, a
// projected pixel runs table read, three multiply steps (the last two on one
// shared 32x32 multiplier), grid row read and row write back, the last skipped
// when the cell is off the grid; a cell read runs a bit-serial divider by the
// grid height, a grid row read (skipped beyond the grid) and waits out any result
// stall; a clear writes each grid row in turn; synchronous reset restores registers
// and runs the same clearing pass over the grid memory; no item is taken until it ends
`timescale 1ns / 1ps
module depth_to_occupancy_grid #(
  parameter int GRID_DIM = dtog_pkg::GRID_DIM_DEF,
  parameter int IMG_COLS = dtog_pkg::IMG_COLS_DEF,
  parameter int IMG_ROWS = dtog_pkg::IMG_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [2:0]                  op,
  input  logic [9:0]                  col,
  input  logic [8:0]                  row,
  input  logic [15:0]                 depth,
  input  logic                        depth_valid,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  green,
  input  logic [7:0]                  red_level,
  input  logic signed [15:0]          trig_sin,
  input  logic signed [15:0]          trig_cos,
  input  logic [dtog_pkg::CELL_W-1:0] cell_index,
  // result items
  output logic                        cell_valid,
  input  logic                        cell_stall,
  output logic [6:0]                  cell_value,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dtog_pkg::*;

  localparam int AW     = $clog2(GRID_DIM);      // grid row / column index
  localparam int DIM_W  = $clog2(GRID_DIM + 1);  // holds a grid size
  localparam int SZ_W   = (DIM_W > 10) ? DIM_W : 10;
  localparam int COL_AW = $clog2(IMG_COLS);
  localparam int ROW_AW = $clog2(IMG_ROWS);
  localparam int PW     = 19;                    // signed cell coordinate

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_PLACE, S_WRITE,
    S_DIV, S_LOOK, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] max_depth;
  logic [15:0] cells_per_meter;
  logic [9:0]  grid_width;
  logic [9:0]  grid_height;
  logic [8:0]  first_row;
  logic [7:0]  obstacle_red_a;
  logic [7:0]  obstacle_red_b;

  // memories: grid as rows of cells, column trig {sin, cos}, row cosine
  logic [GRID_DIM-1:0] grid_mem [GRID_DIM];
  logic [31:0]         col_mem  [IMG_COLS];
  logic [15:0]         row_mem  [IMG_ROWS];

  logic [GRID_DIM-1:0] grid_rdata, grid_wdata;
  logic [AW-1:0]       grid_raddr, grid_waddr;
  logic                grid_re, grid_we;
  logic [31:0]         col_rdata;
  logic [15:0]         row_rdata;

  // item and datapath registers
  logic [15:0]        depth_q;
  logic               occ_q;
  logic               in_range;
  logic [31:0]        p1c, p1s, p2;
  logic [15:0]        rc_mag, cs_mag;
  logic               neg_f, neg_l;
  logic [15:0]        fwd_mag, lat_mag;
  logic [AW-1:0]      px, py;
  logic [AW-1:0]      clr_row;
  logic               res_bit;

  // derived
  logic               acc, cfg_wr;
  logic [DIM_W-1:0]   w_use, h_use;
  logic               pix_ok, occ;
  logic [31:0]        mul_a;
  logic [63:0]        mul_prod;
  logic signed [PW-1:0] fwd_s, lat_s, gx_s, gy_s;
  logic               gx_ok;
  logic               out_free;
  logic [DIM_W-1:0]   rd_x, rd_y;

  // divider
  logic                 div_start, div_done;
  logic [CELL_W-1:0]    div_quot;
  logic [DIM_W-1:0]     div_rem;

  assign pready     = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign acc        = item_valid && !item_stall;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign out_free   = !cell_valid || !cell_stall;

  // grid sizes limited to the storage
  assign w_use = (SZ_W'(grid_width) > SZ_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : DIM_W'(grid_width);
  assign h_use = (SZ_W'(grid_height) > SZ_W'(GRID_DIM)) ? DIM_W'(GRID_DIM)
                                                         : DIM_W'(grid_height);

  // pixel gating and label class, decided at accept
  assign pix_ok = (32'(col) < 32'(IMG_COLS)) && (32'(row) < 32'(IMG_ROWS)) &&
                  depth_valid && (depth <= max_depth) && (row >= first_row);
  assign occ    = (blue == 8'd0) && (green == 8'd0) &&
                  ((red_level == obstacle_red_a) || (red_level == obstacle_red_b));

  // shared wide multiplier for forward then lateral offset
  assign mul_a    = (state == S_MUL3) ? p1s : p1c;
  assign mul_prod = 64'(mul_a) * 64'(p2);

  // target cell from the offsets
  assign fwd_s = neg_f ? -PW'(fwd_mag) : PW'(fwd_mag);
  assign lat_s = neg_l ? -PW'(lat_mag) : PW'(lat_mag);
  assign gx_s  = signed'(PW'(w_use >> 1)) + lat_s;
  assign gy_s  = signed'(PW'(h_use >> 1)) - fwd_s;
  assign gx_ok = !gx_s[PW-1] && !gy_s[PW-1] &&
                 (gx_s < signed'(PW'(w_use))) && (gy_s < signed'(PW'(h_use)));

  // read position to cell: column from the quotient, row from the remainder
  assign div_start = acc && (op == OP_READ);
  assign rd_x      = DIM_W'(w_use - DIM_W'(1) - div_quot[DIM_W-1:0]);
  assign rd_y      = DIM_W'(h_use - DIM_W'(1) - div_rem);

  dtog_div #(
    .NUM_W(CELL_W),
    .DEN_W(DIM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (cell_index),
    .den  (h_use),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // grid port control
  always_comb begin
    grid_re    = 1'b0;
    grid_raddr = AW'(gy_s);
    grid_we    = 1'b0;
    grid_waddr = py;
    grid_wdata = grid_rdata;
    case (state)
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_row;
        grid_wdata = '0;
      end
      S_PLACE: begin
        grid_re = gx_ok;
      end
      S_WRITE: begin
        grid_we        = 1'b1;
        grid_wdata[px] = occ_q;
      end
      S_DIV: begin
        grid_re    = div_done && in_range;
        grid_raddr = AW'(rd_y);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (grid_re) grid_rdata <= grid_mem[grid_raddr];
  end

  // angle tables: loaded and read only from the idle state
  always_ff @(posedge clk) begin
    if (acc && op == OP_LOAD_COL && 32'(col) < 32'(IMG_COLS))
      col_mem[COL_AW'(col)] <= {trig_sin, trig_cos};
    if (acc && op == OP_LOAD_ROW && 32'(row) < 32'(IMG_ROWS))
      row_mem[ROW_AW'(row)] <= trig_cos;
    if (acc && op == OP_PROJECT && pix_ok) begin
      col_rdata <= col_mem[COL_AW'(col)];
      row_rdata <= row_mem[ROW_AW'(row)];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth       <= MAX_DEPTH_RST;
      cells_per_meter <= CELLS_PER_M_RST;
      grid_width      <= GRID_WIDTH_RST;
      grid_height     <= GRID_HEIGHT_RST;
      first_row       <= FIRST_ROW_RST;
      obstacle_red_a  <= RED_A_RST;
      obstacle_red_b  <= RED_B_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MAX_DEPTH:   max_depth       <= pwdata[15:0];
        REG_CELLS_PER_M: cells_per_meter <= pwdata[15:0];
        REG_GRID_WIDTH:  grid_width      <= pwdata[9:0];
        REG_GRID_HEIGHT: grid_height     <= pwdata[9:0];
        REG_FIRST_ROW:   first_row       <= pwdata[8:0];
        REG_RED_A:       obstacle_red_a  <= pwdata[7:0];
        REG_RED_B:       obstacle_red_b  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAX_DEPTH:   prdata = 32'(max_depth);
      REG_CELLS_PER_M: prdata = 32'(cells_per_meter);
      REG_GRID_WIDTH:  prdata = 32'(grid_width);
      REG_GRID_HEIGHT: prdata = 32'(grid_height);
      REG_FIRST_ROW:   prdata = 32'(first_row);
      REG_RED_A:       prdata = 32'(obstacle_red_a);
      REG_RED_B:       prdata = 32'(obstacle_red_b);
      default:         prdata = '0;
    endcase
  end

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_row    <= '0;
      cell_valid <= 1'b0;
    end else begin
      if (cell_valid && !cell_stall) cell_valid <= 1'b0;
      case (state)
        // one grid row a cycle
        S_CLEAR: begin
          clr_row <= clr_row + AW'(1);
          if (clr_row == AW'(GRID_DIM - 1)) begin
            clr_row <= '0;
            state   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            depth_q  <= depth;
            occ_q    <= occ;
            in_range <= (w_use != '0) && (h_use != '0) &&
                        (32'(cell_index) < 32'(w_use) * 32'(h_use));
            case (op)
              OP_CLEAR:   state <= S_CLEAR;
              OP_PROJECT: if (pix_ok) state <= S_MUL1;
              OP_READ:    state <= S_DIV;
              default: ;
            endcase
          end
        end
        // table data in: first partial products and signs
        S_MUL1: begin
          p1c    <= 32'(mag16(row_rdata)) * 32'(mag16(col_rdata[15:0]));
          p2     <= 32'(depth_q) * 32'(cells_per_meter);
          rc_mag <= mag16(row_rdata);
          cs_mag <= mag16(col_rdata[31:16]);
          neg_f  <= row_rdata[15] ^ col_rdata[15];
          neg_l  <= row_rdata[15] ^ col_rdata[31];
          state  <= S_MUL2;
        end
        S_MUL2: begin
          fwd_mag <= mul_prod[63:48];
          p1s     <= 32'(rc_mag) * 32'(cs_mag);
          state   <= S_MUL3;
        end
        S_MUL3: begin
          lat_mag <= mul_prod[63:48];
          state   <= S_PLACE;
        end
        // skip cells off the grid, else fetch the row
        S_PLACE: begin
          px    <= AW'(gx_s);
          py    <= AW'(gy_s);
          state <= gx_ok ? S_WRITE : S_IDLE;
        end
        S_WRITE: state <= S_IDLE;
        S_DIV: begin
          if (div_done) begin
            px      <= AW'(rd_x);
            res_bit <= 1'b0;
            state   <= in_range ? S_LOOK : S_OUT;
          end
        end
        S_LOOK: begin
          res_bit <= grid_rdata[px];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            cell_valid <= 1'b1;
            cell_value <= res_bit ? OCC_VALUE : 7'd0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside a cell read");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> cell_valid)
    else $error("cell result not presented");

  a_value_legal: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> (cell_value == 7'd0 || cell_value == OCC_VALUE))
    else $error("cell value is neither free nor occupied");

  a_clear_blocks: assert property (@(posedge clk)
    state == S_CLEAR |-> item_stall)
    else $error("item taken during grid clear");

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench for the depth-to-occupancy-grid projection block
`timescale 1ns / 1ps
module tb_top;
  import dtog_pkg::*;

  localparam int GDIM = GRID_DIM_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  // a clear walks the whole grid, so an idle block may still be busy this long
  localparam int DRAIN_CYCLES = GDIM + 64;

  // one input item of the block
  typedef struct {
    logic [2:0]         op;
    logic [9:0]         col;
    logic [8:0]         row;
    logic [15:0]        depth;
    logic               dvalid;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [15:0] tsin;
    logic signed [15:0] tcos;
    logic [CELL_W-1:0]  index;
  } pixel_item_t;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  logic [2:0] op = OP_CLEAR;
  logic [9:0] col = 0;
  logic [8:0] row = 0;
  logic [15:0] depth = 0;
  logic depth_valid = 0;
  logic [7:0] blue = 0, green = 0, red_level = 0;
  logic signed [15:0] trig_sin = 0, trig_cos = 0;
  logic [CELL_W-1:0] cell_index = 0;
  logic cell_valid;
  logic cell_stall = 0;
  logic [6:0] cell_value;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  depth_to_occupancy_grid dut (
    .clk, .rst, .item_valid, .item_stall, .op, .col, .row, .depth, .depth_valid,
    .blue, .green, .red_level, .trig_sin, .trig_cos, .cell_index,
    .cell_valid, .cell_stall, .cell_value,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  // predicted state: grid bits, angle tables, registers
  bit grid_occ [GDIM*GDIM];
  logic signed [15:0] col_sin [1024];
  logic signed [15:0] col_cos [1024];
  logic signed [15:0] row_cos [512];
  int loaded_cols [$];
  int loaded_rows [$];
  bit col_loaded [1024];
  bit row_loaded [512];
  int r_max_depth, r_scale, r_width, r_height, r_first_row, r_red_a, r_red_b;

  logic [6:0] cell_values_due [$];
  int errors = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int settings_used = 0;
  bit calm = 0;
  int stall_hold = 0;
  int stall_roll;
  int idle_cycles = 0;

  // grid size in use, limited to the storage
  function automatic int used_w();
    return r_width > GDIM ? GDIM : r_width;
  endfunction

  function automatic int used_h();
    return r_height > GDIM ? GDIM : r_height;
  endfunction

  // trunc(depth * a * b * scale / 2^48), exact product
  function automatic longint grid_offset(int d, int a, int b, int s);
    longint unsigned m;
    bit neg;
    neg = (a < 0) != (b < 0);
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    m = longint'(a) * longint'(b);
    m = m * longint'(d);
    m = m * longint'(s);
    m = m >> 48;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // read position of a grid cell in reversed column-major order
  function automatic int read_pos(int x, int y);
    return (used_w() - 1 - x) * used_h() + (used_h() - 1 - y);
  endfunction

  // update predicted state for one accepted item, queue any cell value it returns
  function automatic void predict_grid(pixel_item_t it);
    int w, h, k;
    longint fwd, lat, gx, gy;
    bit obstacle;
    w = used_w();
    h = used_h();
    case (it.op)
      OP_CLEAR: begin
        foreach (grid_occ[i]) grid_occ[i] = 0;
      end
      OP_PROJECT: begin
        if (it.dvalid && int'(it.depth) <= r_max_depth && int'(it.row) >= r_first_row) begin
          fwd = grid_offset(it.depth, row_cos[it.row], col_cos[it.col], r_scale);
          lat = grid_offset(it.depth, row_cos[it.row], col_sin[it.col], r_scale);
          gx = longint'(w / 2) + lat;
          gy = longint'(h / 2) - fwd;
          if (gx >= 0 && gy >= 0 && gx < w && gy < h) begin
            obstacle = it.blue == 0 && it.green == 0 &&
                       (int'(it.red) == r_red_a || int'(it.red) == r_red_b);
            grid_occ[gy * GDIM + gx] = obstacle;
          end
        end
      end
      OP_READ: begin
        k = it.index;
        if (w != 0 && h != 0 && k < w * h)
          cell_values_due.push_back(grid_occ[(h - 1 - k % h) * GDIM + (w - 1 - k / h)] ?
                                    OCC_VALUE : 7'd0);
        else
          cell_values_due.push_back(7'd0);
      end
      OP_LOAD_COL: begin
        col_sin[it.col] = it.tsin;
        col_cos[it.col] = it.tcos;
        if (!col_loaded[it.col]) loaded_cols.push_back(it.col);
        col_loaded[it.col] = 1;
      end
      OP_LOAD_ROW: begin
        row_cos[it.row] = it.tcos;
        if (!row_loaded[it.row]) loaded_rows.push_back(it.row);
        row_loaded[it.row] = 1;
      end
      default: ;
    endcase
  endfunction

  // random gap before an item: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(pixel_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1;
    op <= it.op;
    col <= it.col;
    row <= it.row;
    depth <= it.depth;
    depth_valid <= it.dvalid;
    blue <= it.blue;
    green <= it.green;
    red_level <= it.red;
    trig_sin <= it.tsin;
    trig_cos <= it.tcos;
    cell_index <= it.index;
    do @(posedge clk); while (item_stall);
    predict_grid(it);
    items_sent++;
  endtask

  // random item of a given operation with all other fields random
  function automatic pixel_item_t rand_item(logic [2:0] code);
    pixel_item_t it;
    it.op = code;
    it.col = $urandom;
    it.row = $urandom;
    it.depth = $urandom;
    it.dvalid = $urandom;
    it.blue = $urandom;
    it.green = $urandom;
    it.red = $urandom;
    it.tsin = $urandom;
    it.tcos = $urandom;
    it.index = $urandom;
    return it;
  endfunction

  // labelled pixel at a loaded column and row
  function automatic pixel_item_t pixel_at(int c, int r, int d, bit obstacle);
    pixel_item_t it;
    it = rand_item(OP_PROJECT);
    it.col = c;
    it.row = r;
    it.depth = d;
    it.dvalid = 1;
    if (obstacle) begin
      it.blue = 0;
      it.green = 0;
      it.red = $urandom_range(0, 1) ? r_red_a : r_red_b;
    end
    return it;
  endfunction

  function automatic pixel_item_t read_item(int k);
    pixel_item_t it;
    it = rand_item(OP_READ);
    it.index = k;
    return it;
  endfunction

  function automatic pixel_item_t load_item(logic [2:0] code, int idx, int s, int c);
    pixel_item_t it;
    it = rand_item(code);
    it.col = idx;
    it.row = idx;
    it.tsin = s;
    it.tcos = c;
    return it;
  endfunction

  // wait for every expected value, then for a possible clear still running
  task automatic wait_idle();
    item_valid <= 0;
    while (cell_values_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_MAX_DEPTH:   r_max_depth = value & 16'hFFFF;
      REG_CELLS_PER_M: r_scale = value & 16'hFFFF;
      REG_GRID_WIDTH:  r_width = value & 10'h3FF;
      REG_GRID_HEIGHT: r_height = value & 10'h3FF;
      REG_FIRST_ROW:   r_first_row = value & 9'h1FF;
      REG_RED_A:       r_red_a = value & 8'hFF;
      REG_RED_B:       r_red_b = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(int md, int sc, int w, int h, int fr, int ra, int rb);
    wait_idle();
    write_reg(REG_MAX_DEPTH, md);
    write_reg(REG_CELLS_PER_M, sc);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_FIRST_ROW, fr);
    write_reg(REG_RED_A, ra);
    write_reg(REG_RED_B, rb);
    settings_used++;
  endtask

  // directed: table extremes, center hits, every rejection, reads and clear
  task automatic test_directed();
    send_item(load_item(OP_LOAD_COL, 0, 0, 32767));
    send_item(load_item(OP_LOAD_COL, 1023, -32768, -32768));
    send_item(load_item(OP_LOAD_COL, 512, 16384, 28377));
    send_item(load_item(OP_LOAD_ROW, 511, 0, 32767));
    send_item(load_item(OP_LOAD_ROW, 0, 0, 32767));
    send_item(load_item(OP_LOAD_ROW, 300, 0, -32768));
    // zero depth lands in the grid center, obstacle then free label
    send_item(pixel_at(0, 511, 0, 1));
    send_item(read_item(read_pos(used_w() / 2, used_h() / 2)));
    send_item(pixel_at(512, 300, 1024, 1));
    send_item(pixel_at(0, 511, 0, 0));
    send_item(read_item(read_pos(used_w() / 2, used_h() / 2)));
    send_item(pixel_at(1023, 511, 2048, 1));
    send_item(read_item($urandom_range(0, 159999)));
    // rejected pixels: depth not a number, too deep, row above first_row
    begin
      pixel_item_t it;
      it = pixel_at(0, 511, 100, 1);
      it.dvalid = 0;
      send_item(it);
    end
    send_item(pixel_at(0, 511, 65535, 1));
    send_item(pixel_at(0, 0, 10, 1));
    // target far beyond the grid edge
    send_item(pixel_at(512, 511, 30720, 1));
    // read beyond grid and at both ends of the order
    send_item(read_item(262143));
    send_item(read_item(0));
    send_item(read_item(159999));
    // unused operation codes
    send_item(rand_item(3'd5));
    send_item(rand_item(3'd6));
    send_item(rand_item(3'd7));
    send_item(rand_item(OP_CLEAR));
    send_item(read_item(read_pos(used_w() / 2, used_h() / 2)));
  endtask

  // random mix dominated by well-formed project and read pairs
  task automatic test_random(int n);
    pixel_item_t it;
    int r, c, rw, d, w, h;
    longint fwd, lat, gx, gy;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i % 60 == 0) calm = $urandom_range(0, 3) == 0;
      c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
      rw = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
      if (r < 45) begin
        // short depths keep most pixels inside the grid
        d = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
        it = pixel_at(c, rw, d, $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) it.dvalid = 0;
        send_item(it);
        // read back the cell just aimed at in two of three cases, when it is in the grid
        w = used_w();
        h = used_h();
        fwd = grid_offset(d, row_cos[rw], col_cos[c], r_scale);
        lat = grid_offset(d, row_cos[rw], col_sin[c], r_scale);
        gx = longint'(w / 2) + lat;
        gy = longint'(h / 2) - fwd;
        if (gx >= 0 && gy >= 0 && gx < w && gy < h && $urandom_range(0, 2) != 0)
          send_item(read_item(read_pos(gx, gy)));
      end else if (r < 75) begin
        w = used_w() * used_h();
        send_item(read_item($urandom_range(0, 4) == 0 || w == 0 ?
                            $urandom_range(0, 262143) : $urandom_range(0, w - 1)));
      end else if (r < 85) begin
        send_item(load_item(OP_LOAD_COL, $urandom_range(0, 1023), $urandom, $urandom));
      end else if (r < 92) begin
        send_item(load_item(OP_LOAD_ROW, $urandom_range(0, 511), $urandom, $urandom));
      end else if (r < 97) begin
        send_item(rand_item($urandom_range(5, 7)));
      end else if (r < 98) begin
        send_item(rand_item(OP_CLEAR));
      end else begin
        // obstacle-like label that misses on blue or green
        it = pixel_at(c, rw, $urandom_range(0, 2000), 1);
        it.blue = $urandom_range(0, 1);
        it.green = it.blue ? 8'd0 : 8'd1;
        send_item(it);
      end
    end
  endtask

  // settings from the reset values to extreme values of the registers and back
  task automatic test_settings();
    test_random(90);
    set_regs(65535, 65535, 512, 512, 0, 0, 255);
    test_random(90);
    set_regs(0, 1, 2, 2, 511, 255, 0);
    test_random(50);
    set_regs(20000, 2560, 1023, 37, 100, 7, 7);
    test_random(90);
    set_regs(65535, 300, 33, 1023, 0, 64, 192);
    test_random(90);
    set_regs(40000, 5120, 0, 9, 0, 1, 2);
    test_random(30);
    set_regs(30720, 5120, 400, 400, 144, 64, 192);
    test_random(60);
  endtask

  // result side: random stall with occasional long holds and calm stretches
  always @(posedge clk) begin
    stall_roll = $urandom_range(0, 999);
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      cell_stall <= 1;
    end else begin
      if (!calm && stall_roll < 4) stall_hold <= $urandom_range(20, 60);
      cell_stall <= !calm && stall_roll < 300;
    end
  end

  // compare every accepted cell value with the oldest prediction
  always @(posedge clk) begin
    if (!rst && cell_valid && !cell_stall) begin
      if (cell_values_due.size() == 0) begin
        $error("cell_value: unexpected result %0d", cell_value);
        errors++;
      end else begin
        if (cell_value !== cell_values_due[0]) begin
          $error("cell_value: expected %0d, got %0d", cell_values_due[0], cell_value);
          errors++;
        end
        void'(cell_values_due.pop_front());
        reads_checked++;
      end
    end
  end

  // watchdog on cycles without any accepted item, accepted result or register access
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (cell_valid && !cell_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    r_max_depth = MAX_DEPTH_RST;
    r_scale = CELLS_PER_M_RST;
    r_width = GRID_WIDTH_RST;
    r_height = GRID_HEIGHT_RST;
    r_first_row = FIRST_ROW_RST;
    r_red_a = RED_A_RST;
    r_red_b = RED_B_RST;
    repeat (8) @(posedge clk);
    rst <= 0;
    test_directed();
    test_settings();
    wait_idle();
    $display("covered %0d items over %0d register settings, %0d cell reads checked",
             items_sent, settings_used + 1, reads_checked);
    if (errors == 0 && cell_values_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
